// ===== rtl/bpit_pkg.sv =====
// ----------------------------------------------------------------------------
// bpit_pkg
// Shared types and constants for the barycentric point-in-triangle test.
// ----------------------------------------------------------------------------
package bpit_pkg;

  localparam int CoordBits      = 24;
  localparam int PointTagBits   = 20;
  localparam int TriTagBits     = 16;
  localparam int LambdaBits     = 32;
  localparam int LambdaFracBits = 30;
  localparam int QuotBits       = 34;
  localparam int DiffBits       = CoordBits + 1;
  localparam int ProdBits       = 2 * DiffBits;
  localparam int MagBits        = 2 * CoordBits + 3;
  localparam int DetBits        = MagBits + 1;
  localparam int FrontStages    = 5;
  localparam int PipeLatency    = FrontStages + QuotBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] vertex1_x;
    logic signed [CoordBits-1:0] vertex1_y;
    logic signed [CoordBits-1:0] vertex2_x;
    logic signed [CoordBits-1:0] vertex2_y;
    logic signed [CoordBits-1:0] vertex3_x;
    logic signed [CoordBits-1:0] vertex3_y;
    logic [PointTagBits-1:0]     point_tag;
    logic [TriTagBits-1:0]       triangle_tag;
  } req_t;

  typedef struct packed {
    logic                         inside_res;
    logic                         degenerate;
    logic signed [LambdaBits-1:0] lambda_one;
    logic signed [LambdaBits-1:0] lambda_two;
    logic signed [LambdaBits-1:0] lambda_three;
    logic [PointTagBits-1:0]      point_tag_out;
    logic [TriTagBits-1:0]        triangle_tag_out;
  } res_t;

  typedef struct packed {
    logic                    valid;
    logic                    degenerate;
    logic                    inside_res;
    logic [2:0]              neg;
    logic [PointTagBits-1:0] point_tag;
    logic [TriTagBits-1:0]   triangle_tag;
  } side_t;

endpackage

// ===== rtl/bpit_front.sv =====
// ----------------------------------------------------------------------------
// bpit_front
// Cramer numerators and determinant, signs and division operands.
// ----------------------------------------------------------------------------
module bpit_front #(
  parameter int LAMBDA_FRAC_BITS = bpit_pkg::LambdaFracBits,
  parameter int REMW             = bpit_pkg::MagBits + 1 + bpit_pkg::QuotBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  bpit_pkg::req_t               request,
  output bpit_pkg::side_t              side,
  output logic [REMW-1:0]              dividend [3],
  output logic [bpit_pkg::MagBits:0]   divisor
);

  localparam int DW = bpit_pkg::DiffBits;
  localparam int PW = bpit_pkg::ProdBits;
  localparam int MW = bpit_pkg::MagBits;
  localparam int TW = bpit_pkg::DetBits;

  logic                   va, vb, vc, vd;
  logic [bpit_pkg::PointTagBits-1:0] pta, ptb, ptc, ptd;
  logic [bpit_pkg::TriTagBits-1:0]   tta, ttb, ttc, ttd;
  logic signed [DW-1:0]   dx [3];
  logic signed [DW-1:0]   dy [3];
  logic signed [PW-1:0]   pp [3];
  logic signed [PW-1:0]   pq [3];
  logic signed [MW-1:0]   num [3];
  logic signed [MW-1:0]   numd [3];
  logic signed [TW-1:0]   det;
  logic [MW-1:0]          det_mag;
  logic [MW-1:0]          num_mag [3];
  logic                   degen;
  logic [2:0]             nonneg;
  logic [2:0]             neg;

  always_ff @(posedge clk) begin
    dx[0] <= DW'(request.vertex1_x) - DW'(request.point_x);
    dy[0] <= DW'(request.vertex1_y) - DW'(request.point_y);
    dx[1] <= DW'(request.vertex2_x) - DW'(request.point_x);
    dy[1] <= DW'(request.vertex2_y) - DW'(request.point_y);
    dx[2] <= DW'(request.vertex3_x) - DW'(request.point_x);
    dy[2] <= DW'(request.vertex3_y) - DW'(request.point_y);
    pta   <= request.point_tag;
    tta   <= request.triangle_tag;
    pp[0] <= PW'(dx[1]) * PW'(dy[2]);
    pq[0] <= PW'(dx[2]) * PW'(dy[1]);
    pp[1] <= PW'(dx[2]) * PW'(dy[0]);
    pq[1] <= PW'(dx[0]) * PW'(dy[2]);
    pp[2] <= PW'(dx[0]) * PW'(dy[1]);
    pq[2] <= PW'(dx[1]) * PW'(dy[0]);
    ptb   <= pta;
    ttb   <= tta;
    for (int i = 0; i < 3; i++) begin
      num[i]  <= MW'(pp[i]) - MW'(pq[i]);
      numd[i] <= num[i];
    end
    ptc   <= ptb;
    ttc   <= ttb;
    det   <= TW'(num[0]) + TW'(num[1]) + TW'(num[2]);
    ptd   <= ptc;
    ttd   <= ttc;
    va <= in_valid && !rst;
    vb <= va && !rst;
    vc <= vb && !rst;
    vd <= vc && !rst;
  end

  always_comb begin
    degen   = (det == '0);
    det_mag = det[TW-1] ? MW'(-det) : MW'(det);
    for (int i = 0; i < 3; i++) begin
      num_mag[i] = numd[i][MW-1] ? MW'(-numd[i]) : MW'(numd[i]);
      nonneg[i]  = (numd[i] == '0) || (numd[i][MW-1] == det[TW-1]);
      neg[i]     = numd[i][MW-1] != det[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    side.valid        <= vd && !rst;
    side.degenerate   <= degen;
    side.inside_res   <= !degen && (&nonneg);
    side.neg          <= neg;
    side.point_tag    <= ptd;
    side.triangle_tag <= ttd;
    divisor           <= {det_mag, 1'b0};
    for (int i = 0; i < 3; i++) begin
      dividend[i] <= (REMW'(num_mag[i]) << (LAMBDA_FRAC_BITS + 1)) + REMW'(det_mag);
    end
  end

endmodule

// ===== rtl/bpit_div_cell.sv =====
// ----------------------------------------------------------------------------
// bpit_div_cell
// One quotient bit of restoring division for the three lanes.
// ----------------------------------------------------------------------------
module bpit_div_cell #(
  parameter int K    = 0,
  parameter int REMW = bpit_pkg::MagBits + 1 + bpit_pkg::QuotBits
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bpit_pkg::side_t                   side_in,
  input  logic [REMW-1:0]                   rem_in [3],
  input  logic [bpit_pkg::QuotBits-1:0]     q_in [3],
  input  logic [bpit_pkg::MagBits:0]        div_in,
  output bpit_pkg::side_t                   side,
  output logic [REMW-1:0]                   rem [3],
  output logic [bpit_pkg::QuotBits-1:0]     q [3],
  output logic [bpit_pkg::MagBits:0]        div
);

  localparam int QB = bpit_pkg::QuotBits;

  logic [REMW-1:0] shifted;
  logic [2:0]      ge;

  always_comb begin
    shifted = REMW'(div_in) << K;
    for (int i = 0; i < 3; i++) begin
      ge[i] = rem_in[i] >= shifted;
    end
  end

  always_ff @(posedge clk) begin
    side <= rst ? '0 : side_in;
    div  <= div_in;
    for (int i = 0; i < 3; i++) begin
      rem[i] <= ge[i] ? rem_in[i] - shifted : rem_in[i];
      q[i]   <= q_in[i] | (QB'(ge[i]) << K);
    end
  end

endmodule

// ===== rtl/bpit_pack.sv =====
// ----------------------------------------------------------------------------
// bpit_pack
// Sign, saturation and result register.
// ----------------------------------------------------------------------------
module bpit_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  bpit_pkg::side_t               side,
  input  logic [bpit_pkg::QuotBits-1:0] q [3],
  output logic                          done,
  output bpit_pkg::res_t                result
);

  localparam int QB = bpit_pkg::QuotBits;
  localparam int LB = bpit_pkg::LambdaBits;

  logic [LB-1:0] lam [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side.degenerate || q[i] == '0) begin
        lam[i] = '0;
      end else if (!side.neg[i]) begin
        lam[i] = (q[i] > QB'({1'b0, {(LB-1){1'b1}}})) ? {1'b0, {(LB-1){1'b1}}}
                                                      : q[i][LB-1:0];
      end else begin
        lam[i] = (q[i] > QB'({1'b1, {(LB-1){1'b0}}})) ? {1'b1, {(LB-1){1'b0}}}
                                                      : LB'(-q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    result.inside_res       <= side.inside_res;
    result.degenerate       <= side.degenerate;
    result.lambda_one       <= lam[0];
    result.lambda_two       <= lam[1];
    result.lambda_three     <= lam[2];
    result.point_tag_out    <= side.point_tag;
    result.triangle_tag_out <= side.triangle_tag;
    done <= side.valid && !rst;
  end

endmodule

// ===== rtl/barycentric_point_in_triangle_top.sv =====
// ----------------------------------------------------------------------------
// barycentric_point_in_triangle_top
// Barycentric point-in-triangle test, one request per cycle.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy stays low. Each
// result appears on result with done high for one cycle. A request passes
// through the difference, product, numerator, determinant and divider operand
// registers, then a chain of 34 division cells, one quotient bit each, then the
// sign and saturation register. The receiver cannot stall the block.
module barycentric_point_in_triangle_top #(
  parameter int LAMBDA_FRAC_BITS = bpit_pkg::LambdaFracBits
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bpit_pkg::req_t  request,
  output logic            done,
  output bpit_pkg::res_t  result
);

  localparam int QB   = bpit_pkg::QuotBits;
  localparam int REMW = bpit_pkg::MagBits + 1 + QB;

  bpit_pkg::side_t             side [QB+1];
  logic [REMW-1:0]             rem  [QB+1][3];
  logic [QB-1:0]               q    [QB+1][3];
  logic [bpit_pkg::MagBits:0]  div  [QB+1];

  assign busy = 1'b0;

  bpit_front #(
    .LAMBDA_FRAC_BITS (LAMBDA_FRAC_BITS),
    .REMW             (REMW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .request  (request),
    .side     (side[0]),
    .dividend (rem[0]),
    .divisor  (div[0])
  );

  assign q[0] = '{default: '0};

  for (genvar s = 0; s < QB; s++) begin : g_cell
    bpit_div_cell #(
      .K    (QB - 1 - s),
      .REMW (REMW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .side_in (side[s]),
      .rem_in  (rem[s]),
      .q_in    (q[s]),
      .div_in  (div[s]),
      .side    (side[s+1]),
      .rem     (rem[s+1]),
      .q       (q[s+1]),
      .div     (div[s+1])
    );
  end

  bpit_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .side   (side[QB]),
    .q      (q[QB]),
    .done   (done),
    .result (result)
  );

endmodule

// ===== rtl/bpit_checker.sv =====
// ----------------------------------------------------------------------------
// bpit_checker
// Port-level checks on the point-in-triangle block.
// ----------------------------------------------------------------------------
module bpit_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input bpit_pkg::req_t request,
  input logic           done,
  input bpit_pkg::res_t result
);

  a_never_busy : assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, bpit_pkg::PipeLatency))
    else $error("result without request");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> !result.inside_res && result.lambda_one == '0
      && result.lambda_two == '0 && result.lambda_three == '0)
    else $error("degenerate result not cleared");

  a_inside_signs : assert property (@(posedge clk) disable iff (rst)
    done && result.inside_res |-> !result.lambda_one[31] && !result.lambda_two[31]
      && !result.lambda_three[31])
    else $error("inside with negative weight");

  a_tag_pass : assert property (@(posedge clk) disable iff (rst)
    done |-> result.triangle_tag_out
      == $past(request.triangle_tag, bpit_pkg::PipeLatency))
    else $error("triangle tag altered");

endmodule

bind barycentric_point_in_triangle_top bpit_checker u_bpit_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

// ===== verif/tb_barycentric_point_in_triangle_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_point_in_triangle_top
// Self-checking bench for the barycentric point-in-triangle test: requests go
// in with random gaps, but for a back-to-back run in the random test; each
// result is predicted in the bench and compared whole in order of issue.
// ----------------------------------------------------------------------------
module tb_barycentric_point_in_triangle_top;

  localparam int MaxCycles = 200000;
  localparam int CW  = bpit_pkg::CoordBits;
  localparam int PTW = bpit_pkg::PointTagBits;
  localparam int TTW = bpit_pkg::TriTagBits;
  localparam int LW  = bpit_pkg::LambdaBits;
  localparam int LFB = bpit_pkg::LambdaFracBits;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  bpit_pkg::req_t request = '0;
  bpit_pkg::res_t result;

  bpit_pkg::res_t expected_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   no_gaps = 1'b0;

  barycentric_point_in_triangle_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  function automatic logic signed [LW-1:0] lambda_div(
    input logic signed [127:0] num, input logic signed [127:0] den);
    logic [127:0] nmag, dmag, q;
    logic neg;
    nmag = num < 0 ? -num : num;
    dmag = den < 0 ? -den : den;
    q = ((nmag << (LFB + 1)) + dmag) / (dmag << 1);
    neg = (num < 0) != (den < 0);
    if (q == 0) return '0;
    if (!neg) return q > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    return q > 128'h8000_0000 ? 32'h8000_0000 : -q[31:0];
  endfunction

  function automatic bpit_pkg::res_t barycentric_predict(input bpit_pkg::req_t r);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, n1, n2, n3, det;
    bpit_pkg::res_t e;
    x1 = r.vertex1_x - r.point_x; y1 = r.vertex1_y - r.point_y;
    x2 = r.vertex2_x - r.point_x; y2 = r.vertex2_y - r.point_y;
    x3 = r.vertex3_x - r.point_x; y3 = r.vertex3_y - r.point_y;
    n1 = x2 * y3 - x3 * y2;
    n2 = x3 * y1 - x1 * y3;
    n3 = x1 * y2 - x2 * y1;
    det = n1 + n2 + n3;
    e = '0;
    e.point_tag_out = r.point_tag;
    e.triangle_tag_out = r.triangle_tag;
    if (det == 0) begin
      e.degenerate = 1'b1;
    end else begin
      e.inside_res = (n1 == 0 || (n1 < 0) == (det < 0)) &&
                     (n2 == 0 || (n2 < 0) == (det < 0)) &&
                     (n3 == 0 || (n3 < 0) == (det < 0));
      e.lambda_one = lambda_div(n1, det);
      e.lambda_two = lambda_div(n2, det);
      e.lambda_three = lambda_div(n3, det);
    end
    return e;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else if (result !== expected_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p actual %p", expected_q[0], result);
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
  end

  task automatic send_request(input bpit_pkg::req_t r);
    while (!no_gaps && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q = {expected_q, barycentric_predict(r)};
  endtask

  task automatic send_triangle(input int px, py, ax, ay, bx, by, cx, cy);
    bpit_pkg::req_t r;
    r.point_x = CW'(px); r.point_y = CW'(py);
    r.vertex1_x = CW'(ax); r.vertex1_y = CW'(ay);
    r.vertex2_x = CW'(bx); r.vertex2_y = CW'(by);
    r.vertex3_x = CW'(cx); r.vertex3_y = CW'(cy);
    r.point_tag = PTW'($urandom); r.triangle_tag = TTW'($urandom);
    send_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    localparam int One = 1 << 16;
    localparam int Hi = 8388607;
    localparam int Lo = -8388608;
    send_triangle(One/4, One/4, 0, 0, One, 0, 0, One);
    send_triangle(2*One, 2*One, 0, 0, One, 0, 0, One);
    send_triangle(0, 0, 0, 0, One, 0, 0, One);
    send_triangle(One/2, 0, 0, 0, One, 0, 0, One);
    send_triangle(One/3, One/3, 0, 0, 0, One, One, 0);
    send_triangle(5, 5, 0, 0, One, One, 2*One, 2*One);
    send_triangle(7, 9, 3, 3, 3, 3, 3, 3);
    send_triangle(Hi, Hi, Lo, Lo, Hi, Lo, Lo, Hi);
    send_triangle(Lo, Lo, Hi, Hi, Hi, Hi - 1, Hi - 1, Hi);
    send_triangle(0, 0, Hi, Lo, Lo, Hi, Hi, Hi);
    send_triangle(Lo, Hi, 0, 0, 1, 0, 0, 1);
    send_triangle(1, 1, 0, 0, 3, 0, 0, 3);
    send_triangle(-1, -1, Lo, Lo, Hi, Hi, Lo, Hi);
    send_triangle(Hi, Lo, Hi, Lo, Hi, Lo, Lo, Hi);
    send_request('1);
    send_request('0);
  endtask

  task automatic test_random(input int count);
    bpit_pkg::req_t r;
    logic [255:0] raw;
    int sh;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2 && i < count / 2 + 200);
      raw = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(bpit_pkg::req_t)-1:0];
      sh = $urandom_range(23);
      if ($urandom_range(3) != 0) begin
        r.point_x >>>= sh; r.point_y >>>= sh;
        r.vertex1_x >>>= sh; r.vertex1_y >>>= sh;
        r.vertex2_x >>>= sh; r.vertex2_y >>>= sh;
        r.vertex3_x >>>= sh; r.vertex3_y >>>= sh;
      end
      if ($urandom_range(15) == 0) r.vertex3_x = r.vertex2_x;
      if ($urandom_range(15) == 0) begin
        r.vertex3_x = r.vertex2_x; r.vertex3_y = r.vertex2_y;
      end
      if ($urandom_range(15) == 0) begin
        r.point_x = r.vertex1_x; r.point_y = r.vertex1_y;
      end
      send_request(r);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(1830);
    drain();
    repeat (bpit_pkg::PipeLatency + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bpit_pkg.sv
rtl/bpit_front.sv
rtl/bpit_div_cell.sv
rtl/bpit_pack.sv
rtl/barycentric_point_in_triangle_top.sv
rtl/bpit_checker.sv
verif/tb_barycentric_point_in_triangle_top.sv
